>>> hdl/bounded_deque_with_delete_assert.svh
// Assertion macros used by the checker file of the deque block.
// Depends on nothing; the user supplies the clock and reset names clk and rst.
`ifndef BOUNDED_DEQUE_WITH_DELETE_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_DELETE_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define BDD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed");

// Next-cycle implication, quiet during reset.
`define BDD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

>>> hdl/bdd_pkg.sv
// Shared types, sizes and request codes of the bounded deque block.
// No dependencies; every other file but the assertion header refers to it by scoped names.
`default_nettype none

package bdd_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int FUNC_W = 3;
  localparam int POS_W  = 6;
  localparam int FILL_W = 7;

  localparam logic [FUNC_W-1:0] FN_PUSH_TAIL = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_HEAD = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_HEAD  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_TAIL  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DELETE    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ      = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] data_in;
    logic [POS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] data_out;
    logic                     is_empty;
    logic [FILL_W-1:0]        fill;
  } rsp_t;

  // Broadcast from the control to every cell of the row.
  typedef struct packed {
    logic                     push_tail;
    logic                     push_head;
    logic                     pop_head;
    logic                     delete_val;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         sel;
  } ctl_t;

endpackage

`default_nettype wire

>>> hdl/bdd_cell.sv
// One storage cell of the deque row: holds one entry, compares it, shifts it.
// Depends on bdd_pkg.
`default_nettype none

module bdd_cell (
  input  wire logic                             clk,
  input  wire logic [bdd_pkg::IDX_W-1:0]        idx,
  input  wire bdd_pkg::ctl_t                    ctl,
  input  wire logic signed [bdd_pkg::DATA_W-1:0] left_data,
  input  wire logic signed [bdd_pkg::DATA_W-1:0] right_data,
  input  wire logic                             found_in,
  output logic                                  found_out,
  output logic signed [bdd_pkg::DATA_W-1:0]     data,
  output logic signed [bdd_pkg::DATA_W-1:0]     rd_data
);

  logic                             occupied;
  logic                             hit;
  logic signed [bdd_pkg::DATA_W-1:0] data_next;

  always_comb begin
    occupied  = bdd_pkg::CNT_W'(idx) < ctl.count;
    hit       = occupied && (data == ctl.value);
    found_out = found_in | hit;
    rd_data   = (idx == ctl.sel) ? data : '0;

    data_next = data;
    if (ctl.push_tail && (bdd_pkg::CNT_W'(idx) == ctl.count)) begin
      data_next = ctl.value;
    end
    if (ctl.push_head) begin
      data_next = (idx == '0) ? ctl.value : left_data;
    end
    // Close the gap: take the right neighbor from the removed slot onward.
    if (ctl.pop_head || (ctl.delete_val && found_out)) begin
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

>>> hdl/bdd_row.sv
// Row of deque cells with the first-match chain and the read-out OR tree.
// Depends on bdd_pkg and bdd_cell.
`default_nettype none

module bdd_row (
  input  wire logic                          clk,
  input  wire bdd_pkg::ctl_t                 ctl,
  output logic                               found,
  output logic signed [bdd_pkg::DATA_W-1:0]  rd_data
);

  logic signed [bdd_pkg::DATA_W-1:0] cell_data [bdd_pkg::DEPTH];
  logic signed [bdd_pkg::DATA_W-1:0] cell_rd   [bdd_pkg::DEPTH];
  logic [bdd_pkg::DEPTH:0]           chain;

  assign chain[0] = 1'b0;
  assign found    = chain[bdd_pkg::DEPTH];

  for (genvar g = 0; g < bdd_pkg::DEPTH; g++) begin : g_cell
    logic signed [bdd_pkg::DATA_W-1:0] left_d;
    logic signed [bdd_pkg::DATA_W-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_inner_l
      assign left_d = cell_data[g-1];
    end
    if (g == bdd_pkg::DEPTH - 1) begin : g_last
      assign right_d = cell_data[g];
    end else begin : g_inner_r
      assign right_d = cell_data[g+1];
    end

    bdd_cell u_cell (
      .clk        (clk),
      .idx        (bdd_pkg::IDX_W'(g)),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .found_in   (chain[g]),
      .found_out  (chain[g+1]),
      .data       (cell_data[g]),
      .rd_data    (cell_rd[g])
    );
  end

  // At most one cell matches sel, so an OR merges the row.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < bdd_pkg::DEPTH; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/bounded_deque_with_delete.sv
// Top level of the bounded deque: request decode, entry count, result register.
// Depends on bdd_pkg and bdd_row.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | bdd_pkg::req_t (func, data_in, position)
//   rsp     | out       | rsp_valid/rsp_ready  | bdd_pkg::rsp_t (ok, data_out, is_empty, fill)
//
// Every item completes in the cycle it is accepted; its result shows in the cycle after, from the result register.
// One item per cycle sustained while results are taken; the cycle is set by the delete search, a compare in
// every cell followed by the first-match chain that ripples down the cell row.
// Reset clears the count and the result valid flag; the result data and the cell contents are not cleared.
// A stalled result holds in the result register; a new item is taken only when the
// register is empty or drains in the same cycle.
`default_nettype none

module bounded_deque_with_delete (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire bdd_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output bdd_pkg::rsp_t       rsp
);

  logic [bdd_pkg::CNT_W-1:0]         count;
  logic [bdd_pkg::CNT_W-1:0]         count_next;
  bdd_pkg::ctl_t                     ctl;
  bdd_pkg::rsp_t                     rsp_next;
  logic                              accept;
  logic                              full;
  logic                              empty;
  logic                              pos_ok;
  logic                              found;
  logic                              ok;
  logic                              use_rd;
  logic signed [bdd_pkg::DATA_W-1:0] rd_data;

  // Take a new item whenever the result register is free or drains now.
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  // Decode the request into one broadcast to the cells.
  always_comb begin
    full   = count == bdd_pkg::CNT_W'(bdd_pkg::DEPTH);
    empty  = count == '0;
    pos_ok = 32'(req.position) < 32'(count);

    ctl            = '0;
    ctl.count      = count;
    ctl.value      = req.data_in;
    ok             = 1'b0;
    use_rd         = 1'b0;
    count_next     = count;

    unique case (req.func)
      bdd_pkg::FN_PUSH_TAIL: begin
        ok            = !full;
        ctl.push_tail = accept && !full;
        if (!full) count_next = count + 1'b1;
      end
      bdd_pkg::FN_PUSH_HEAD: begin
        ok            = !full;
        ctl.push_head = accept && !full;
        if (!full) count_next = count + 1'b1;
      end
      bdd_pkg::FN_POP_HEAD: begin
        ok           = !empty;
        use_rd       = 1'b1;
        ctl.sel      = '0;
        ctl.pop_head = accept && !empty;
        if (!empty) count_next = count - 1'b1;
      end
      bdd_pkg::FN_POP_TAIL: begin
        ok      = !empty;
        use_rd  = 1'b1;
        // Wraps when empty, but the result is then dropped anyway.
        ctl.sel = bdd_pkg::IDX_W'(count - 1'b1);
        if (!empty) count_next = count - 1'b1;
      end
      bdd_pkg::FN_DELETE: begin
        // Cells shift only from the first match onward, so no match moves nothing.
        ok             = found;
        ctl.delete_val = accept;
        if (found) count_next = count - 1'b1;
      end
      bdd_pkg::FN_READ: begin
        ok      = pos_ok;
        use_rd  = 1'b1;
        ctl.sel = bdd_pkg::IDX_W'(req.position);
      end
      default: begin
        ok = 1'b0;
      end
    endcase

    rsp_next.ok       = ok;
    rsp_next.data_out = (ok && use_rd) ? rd_data : '0;
    rsp_next.is_empty = count_next == '0;
    rsp_next.fill     = bdd_pkg::FILL_W'(count_next);
  end

  bdd_row u_row (
    .clk     (clk),
    .ctl     (ctl),
    .found   (found),
    .rd_data (rd_data)
  );

  // Advance the count on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Hold the result until taken; load the next one as the old one drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bdd_chk.sv
// Port-level checker for the bounded deque, attached to the top level by bind.
// Depends on bdd_pkg and bounded_deque_with_delete_assert.svh.
`default_nettype none

`include "bounded_deque_with_delete_assert.svh"

module bdd_chk (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire bdd_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire bdd_pkg::rsp_t rsp
);

  // Empty flag must agree with the reported fill.
  `BDD_ASSERT_NOW(a_empty_fill, rsp_valid, rsp.is_empty == (rsp.fill == '0))

  // Fill never exceeds the capacity.
  `BDD_ASSERT_NOW(a_fill_cap, rsp_valid, 32'(rsp.fill) <= 32'(bdd_pkg::DEPTH))

  // A failed request reports no data.
  `BDD_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp.ok, rsp.data_out == '0)

  // A stalled result stays put.
  `BDD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind bounded_deque_with_delete bdd_chk u_bdd_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
